/* hw/rtl/offset_sorted_store_with_eviction_unit_defines.svh */
// Assertion macros used by the assertion checker of the sorted store.
`ifndef OFFSET_SORTED_STORE_WITH_EVICTION_UNIT_DEFINES_SVH
`define OFFSET_SORTED_STORE_WITH_EVICTION_UNIT_DEFINES_SVH

// Check a property on every rising edge outside of reset.
`define OSSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define OSSE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/osse_pkg.sv */
`default_nettype none

package osse_pkg;

    localparam int VAL_W = 48;
    localparam int AMT_W = 31;
    localparam int DEP_W = 32;

    // Operation codes of an input word
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_RAISE  = 2'd1,
        OP_LOWER  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef struct packed {
        t_op              operation;
        logic [AMT_W-1:0] amount;
    } t_in_word;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] ranked_value;
        logic [DEP_W-1:0]        departed_total;
        logic                    overflow;
    } t_out_word;

    // Command broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    shl;
        logic signed [VAL_W-1:0] rel;
    } t_cell_ctl;

    // What a cell shows its neighbors
    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic                    vld;
        logic                    gt;
        logic                    open;
    } t_cell_link;

    // Clamp a 49-bit signed sum to the signed 48-bit range
    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [VAL_W:0] v);
        logic signed [VAL_W-1:0] r;
        if (v[VAL_W] != v[VAL_W-1]) begin
            r = v[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/osse_cell.sv */
`default_nettype none

module osse_cell import osse_pkg::*; #(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic [IDX_W-1:0]        i_sel,
    input  wire t_cell_link              i_prev,
    input  wire t_cell_link              i_next,
    input  wire logic signed [VAL_W-1:0] i_prev_tap,
    output t_cell_link                   o_link,
    output logic signed [VAL_W-1:0]      o_tap
);

    logic signed [VAL_W-1:0] r_val;
    logic                    r_vld;
    logic signed [VAL_W-1:0] r_tap;
    logic                    w_gt;
    logic                    w_open;
    logic                    w_take_new;
    logic                    w_hit;

    // Entry is larger than the value being inserted, so it moves up
    assign w_gt       = r_vld && (r_val > i_ctl.rel);
    assign w_open     = w_gt || !r_vld;
    // First open cell takes the new value
    assign w_take_new = w_open && !i_prev.open;
    assign w_hit      = (i_sel == CELL_IDX[IDX_W-1:0]);

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.ins) begin
            if (i_prev.gt || w_take_new) begin
                r_vld <= 1'b1;
            end
        end else if (i_ctl.shl) begin
            r_vld <= i_next.vld;
        end
    end

    // Shift entries up on insert, down on evict; pass the read tap along
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_prev.gt) begin
                r_val <= i_prev.val;
            end else if (w_take_new) begin
                r_val <= i_ctl.rel;
            end
        end else if (i_ctl.shl) begin
            r_val <= i_next.val;
        end
        r_tap <= w_hit ? r_val : i_prev_tap;
    end

    assign o_link.val  = r_val;
    assign o_link.vld  = r_vld;
    assign o_link.gt   = w_gt;
    assign o_link.open = w_open;
    assign o_tap       = r_tap;

endmodule

`default_nettype wire

/* hw/rtl/offset_sorted_store_with_eviction_unit.sv */
`default_nettype none

// Sorted multiset of up to CAPACITY values kept relative to a global offset,
// held in a chain of cells that shift entries to their neighbors. An item is
// taken when start is high and busy is low; its single result word appears
// on o_result for exactly one cycle with o_strobe, in the cycle after the
// last busy cycle (or after the item is taken, if busy never rose), and must
// be taken then since the receiver cannot stall. Raise, a dropped insert and
// a rank that is out of range answer without raising busy. An admitted insert
// registers the relative value, then every cell compares and shifts at once.
// Lower moves the offset, then the chain shifts down by one entry per cycle
// while the lowest cell is below the minimum. A valid query stays busy while
// the selected entry rides the read tap to the end of the chain. The minimum
// register may be written at any time the block is idle; reset clears the
// store, offset, minimum and departed count.
module offset_sorted_store_with_eviction_unit import osse_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_in_word         i_item,
    input  wire logic             i_cfg_we,
    input  wire logic [AMT_W-1:0] i_cfg_wdata,
    output logic                  o_strobe,
    output t_out_word             o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_EVICT,
        S_QUERY
    } t_state;

    t_state                  r_state;
    logic signed [VAL_W-1:0] r_off;
    logic [AMT_W-1:0]        r_min;
    logic [CNT_W-1:0]        r_cnt_e;
    logic [DEP_W-1:0]        r_dep;
    logic [CNT_W-1:0]        r_qcnt;
    logic                    r_strobe;
    logic signed [VAL_W-1:0] r_rel;
    logic [IDX_W-1:0]        r_sel;
    t_out_word               r_out;
    t_out_word               n_out;

    t_cell_ctl               w_ctl;
    t_cell_link              w_link [CAPACITY];
    logic signed [VAL_W-1:0] w_tap  [CAPACITY];

    logic                    w_acc;
    logic                    w_admit;
    logic                    w_full;
    logic                    w_k_ok;
    logic [AMT_W-1:0]        w_cnt_ext;
    logic [AMT_W-1:0]        w_diff;
    logic signed [VAL_W:0]   w_amt_ext;
    logic signed [VAL_W:0]   w_off_ext;
    logic signed [VAL_W:0]   w_min_ext;
    logic signed [VAL_W:0]   w_low_sum;
    logic signed [VAL_W:0]   w_rank_sum;
    logic signed [VAL_W-1:0] w_ins_rel;
    logic signed [VAL_W-1:0] w_raise;
    logic signed [VAL_W-1:0] w_lower;
    logic                    w_below;
    logic [DEP_W-1:0]        w_dep_inc;

    // Decode the accepted word
    assign busy      = (r_state != S_IDLE);
    assign w_acc     = start && !busy;
    assign w_admit   = (i_item.amount >= r_min);
    assign w_full    = (r_cnt_e == CNT_W'(CAPACITY));
    assign w_cnt_ext = AMT_W'(r_cnt_e);
    assign w_k_ok    = (i_item.amount != '0) && (i_item.amount <= w_cnt_ext);
    assign w_diff    = w_cnt_ext - i_item.amount;

    // Offset arithmetic, one wide add per path
    assign w_amt_ext  = $signed({{(VAL_W + 1 - AMT_W){1'b0}}, i_item.amount});
    assign w_off_ext  = $signed({r_off[VAL_W-1], r_off});
    assign w_min_ext  = $signed({{(VAL_W + 1 - AMT_W){1'b0}}, r_min});
    assign w_ins_rel  = sat48(w_amt_ext - w_off_ext);
    assign w_raise    = sat48(w_off_ext + w_amt_ext);
    assign w_lower    = sat48(w_off_ext - w_amt_ext);

    // Lowest entry falls below the minimum
    assign w_low_sum  = $signed({w_link[0].val[VAL_W-1], w_link[0].val}) + w_off_ext;
    assign w_below    = w_link[0].vld && (w_low_sum < w_min_ext);

    // Actual value leaving the end of the read tap
    assign w_rank_sum = $signed({w_tap[CAPACITY-1][VAL_W-1], w_tap[CAPACITY-1]}) + w_off_ext;

    assign w_dep_inc  = (r_dep == '1) ? r_dep : r_dep + DEP_W'(1);

    // Broadcast the cell command
    assign w_ctl.ins = (r_state == S_INSERT);
    assign w_ctl.shl = (r_state == S_EVICT) && w_below;
    assign w_ctl.rel = r_rel;

    // Build the chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_link              w_prev;
        t_cell_link              w_next;
        logic signed [VAL_W-1:0] w_prev_tap;

        if (g == 0) begin : g_first
            assign w_prev     = '0;
            assign w_prev_tap = '0;
        end else begin : g_mid
            assign w_prev     = w_link[g-1];
            assign w_prev_tap = w_tap[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_link[g+1];
        end

        osse_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_sel      (r_sel),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .i_prev_tap (w_prev_tap),
            .o_link     (w_link[g]),
            .o_tap      (w_tap[g])
        );
    end

    // Assemble the result word
    always_comb begin
        n_out.found          = (r_state == S_QUERY);
        n_out.ranked_value   = n_out.found ? sat48(w_rank_sum) : '0;
        n_out.departed_total = r_dep;
        n_out.overflow       = (r_state == S_IDLE) && w_acc &&
                               (i_item.operation == OP_INSERT) && w_admit && w_full;
    end

    // Sequence each operation and hold the store state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_off    <= '0;
            r_min    <= '0;
            r_cnt_e  <= '0;
            r_dep    <= '0;
            r_qcnt   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_item.operation)
                            OP_INSERT: begin
                                if (w_admit && !w_full) begin
                                    r_state <= S_INSERT;
                                end else begin
                                    r_strobe <= 1'b1;
                                end
                            end
                            OP_RAISE: begin
                                r_off    <= w_raise;
                                r_strobe <= 1'b1;
                            end
                            OP_LOWER: begin
                                r_off   <= w_lower;
                                r_state <= S_EVICT;
                            end
                            OP_QUERY: begin
                                if (w_k_ok) begin
                                    r_qcnt  <= '0;
                                    r_state <= S_QUERY;
                                end else begin
                                    r_strobe <= 1'b1;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INSERT: begin
                    r_cnt_e  <= r_cnt_e + CNT_W'(1);
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_EVICT: begin
                    if (w_below) begin
                        r_cnt_e <= r_cnt_e - CNT_W'(1);
                        r_dep   <= w_dep_inc;
                    end else begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_QUERY: begin
                    if (r_qcnt == CNT_W'(CAPACITY)) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_qcnt <= r_qcnt + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Capture operands and the result word
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_rel <= w_ins_rel;
            r_sel <= w_diff[IDX_W-1:0];
        end
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* hw/rtl/osse_chk.sv */
`default_nettype none

`include "offset_sorted_store_with_eviction_unit_defines.svh"

module osse_chk import osse_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      o_strobe,
    input wire t_out_word o_result
);

    logic [DEP_W-1:0] w_dep;

    assign w_dep = o_result.departed_total;

    // Reset leaves the block idle with no word pending
    `OSSE_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_strobe && !busy, "not idle after reset")

    // An accepted word either answers at once or keeps the block busy
    `OSSE_ASSERT(a_accept_progress, start && !busy |=> o_strobe || busy, "accepted word lost")

    // A word without a hit carries a zero value
    `OSSE_ASSERT(a_miss_zero, o_strobe && !o_result.found |-> o_result.ranked_value == '0, "miss value")

    // Departed count never drops between back-to-back words
    `OSSE_ASSERT(a_dep_mono, o_strobe && $past(o_strobe) |-> w_dep >= $past(w_dep), "departed fell")

endmodule

bind offset_sorted_store_with_eviction_unit osse_chk u_osse_chk (.*);

`default_nettype wire

/* dv/offset_sorted_store_with_eviction_unit_checker.sv */
`timescale 1ns / 1ps

// Watch the item and result channels of the sorted store, predict each result
// word from a private copy of the store and compare it field by field.
module offset_sorted_store_with_eviction_unit_checker import osse_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_busy,
    input  wire t_in_word         i_item,
    input  wire logic             i_cfg_we,
    input  wire logic [AMT_W-1:0] i_cfg_wdata,
    input  wire logic             i_strobe,
    input  wire t_out_word        i_result,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_found_count,
    output int                    o_drop_count
);

    localparam longint VAL_MAX    = (longint'(1) << (VAL_W - 1)) - 1;
    localparam longint VAL_MIN    = -(longint'(1) << (VAL_W - 1));
    localparam longint DEP_MAX    = (longint'(1) << DEP_W) - 1;
    localparam int     SHOW_LIMIT = 40;

    // Predicted store: relative values sorted ascending, plus offset and counters
    logic signed [VAL_W-1:0] rel_entries [CAPACITY];
    int                      fill;
    logic signed [VAL_W-1:0] offset;
    logic [DEP_W-1:0]        departed;
    logic [AMT_W-1:0]        minimum;

    t_out_word expected_words [$];
    t_out_word want;
    int        fails;
    int        hits;
    int        drops;

    // Clamp to the signed 48-bit range
    function automatic longint clamp_value(input longint v);
        if (v > VAL_MAX) begin
            return VAL_MAX;
        end
        if (v < VAL_MIN) begin
            return VAL_MIN;
        end
        return v;
    endfunction

    // Apply one input word to the predicted store and build its result word
    task automatic apply_word(input t_in_word w, output t_out_word r);
        longint amt;
        longint rel;
        int     pos;
        int     drop;
        int     k;
        amt = longint'(w.amount);
        r   = '0;
        case (w.operation)
            OP_INSERT: begin
                if (amt >= longint'(minimum)) begin
                    if (fill >= CAPACITY) begin
                        r.overflow = 1'b1;
                        drops++;
                    end else begin
                        rel = clamp_value(amt - longint'(offset));
                        pos = fill;
                        while (pos > 0 && longint'(rel_entries[pos-1]) > rel) begin
                            rel_entries[pos] = rel_entries[pos-1];
                            pos--;
                        end
                        rel_entries[pos] = rel;
                        fill++;
                    end
                end
            end
            OP_RAISE: begin
                offset = clamp_value(longint'(offset) + amt);
            end
            OP_LOWER: begin
                offset = clamp_value(longint'(offset) - amt);
                // Evict from the low end while the actual value is under the minimum
                drop = 0;
                while (drop < fill &&
                       longint'(rel_entries[drop]) + longint'(offset) < longint'(minimum)) begin
                    drop++;
                end
                for (k = 0; k < fill - drop; k++) begin
                    rel_entries[k] = rel_entries[k + drop];
                end
                fill -= drop;
                if (longint'(departed) + drop > DEP_MAX) begin
                    departed = '1;
                end else begin
                    departed = departed + drop;
                end
            end
            default: begin
                if (amt >= 1 && amt <= fill) begin
                    r.found        = 1'b1;
                    r.ranked_value = clamp_value(longint'(rel_entries[fill - int'(amt)]) +
                                                 longint'(offset));
                    hits++;
                end
            end
        endcase
        r.departed_total = departed;
    endtask

    // Print one line per mismatch, up to a limit, and count every one
    task automatic report_mismatch(input string what);
        if (fails < SHOW_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        fails++;
    endtask

    // Compare the result word of this cycle, then take any new item and write
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill     = 0;
            offset   = '0;
            departed = '0;
            minimum  = '0;
            expected_words.delete();
        end else begin
            if (i_strobe) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with no item waiting");
                end else begin
                    want = expected_words.pop_front();
                    if (i_result.found !== want.found) begin
                        report_mismatch($sformatf("found got %b, want %b",
                                                  i_result.found, want.found));
                    end
                    if (i_result.ranked_value !== want.ranked_value) begin
                        report_mismatch($sformatf("ranked_value got %h, want %h",
                                                  i_result.ranked_value, want.ranked_value));
                    end
                    if (i_result.departed_total !== want.departed_total) begin
                        report_mismatch($sformatf("departed_total got %h, want %h",
                                                  i_result.departed_total,
                                                  want.departed_total));
                    end
                    if (i_result.overflow !== want.overflow) begin
                        report_mismatch($sformatf("overflow got %b, want %b",
                                                  i_result.overflow, want.overflow));
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_word(i_item, want);
                expected_words.push_back(want);
            end
            if (i_cfg_we) begin
                minimum = i_cfg_wdata;
            end
        end
        o_pending     <= expected_words.size();
        o_fail_count  <= fails;
        o_found_count <= hits;
        o_drop_count  <= drops;
    end

endmodule

/* dv/offset_sorted_store_with_eviction_unit_tb.sv */
`timescale 1ns / 1ps

module offset_sorted_store_with_eviction_unit_tb;
    import osse_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int RANDOM_WORDS  = 1550;
    localparam int PHASE_WORDS   = 310;
    localparam int SEGMENT_WORDS = 50;
    localparam int BURST_WORDS   = 70;
    // Full-scale steps that swing the offset far beyond the 32-bit range
    localparam int SWEEP_STEPS   = 8;
    // Room for about 1.6k words and their idle gaps, several times over
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [AMT_W-1:0] AMOUNT_MAX = '1;

    typedef enum int {
        MIX_FILL,
        MIX_EVEN,
        MIX_DRAIN
    } t_mix;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    t_in_word         item      = '0;
    logic             cfg_we    = 1'b0;
    logic [AMT_W-1:0] cfg_wdata = '0;
    logic             busy;
    logic             strobe;
    t_out_word        result;

    int               fail_count;
    int               pending;
    int               found_count;
    int               drop_count;
    int               cycles = 0;
    int               sent [4];
    int               settings = 0;
    logic [AMT_W-1:0] cur_min = '0;
    logic [AMT_W-1:0] phase_min [5];

    offset_sorted_store_with_eviction_unit #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .o_strobe   (strobe),
        .o_result   (result)
    );

    offset_sorted_store_with_eviction_unit_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_strobe     (strobe),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_found_count(found_count),
        .o_drop_count (drop_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words pending", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Idle at random, then hold the word until the block takes it
    task automatic send_word(input t_op op, input logic [AMT_W-1:0] amt, input int idle_pct);
        t_in_word w;
        w.operation = op;
        w.amount    = amt;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy);
        sent[op]++;
    endtask

    // Drain every outstanding result word
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
    endtask

    task automatic write_minimum(input logic [AMT_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cur_min    = v;
        settings++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Value a little above the current minimum, held in range
    function automatic logic [AMT_W-1:0] near_minimum(input int spread);
        longint v;
        v = longint'(cur_min) + $urandom_range(spread);
        if (v > longint'(AMOUNT_MAX)) begin
            v = longint'(AMOUNT_MAX);
        end
        return v[AMT_W-1:0];
    endfunction

    // Draw one random word; the mix sets how the store tends to fill or drain
    function automatic t_in_word draw_word(input t_mix mix);
        t_in_word w;
        int       r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                w.operation = r < 70 ? OP_INSERT : r < 90 ? OP_QUERY :
                              r < 95 ? OP_RAISE  : OP_LOWER;
            end
            MIX_EVEN: begin
                w.operation = r < 25 ? OP_INSERT : r < 50 ? OP_QUERY :
                              r < 75 ? OP_RAISE  : OP_LOWER;
            end
            default: begin
                w.operation = r < 15 ? OP_INSERT : r < 40 ? OP_QUERY :
                              r < 60 ? OP_RAISE  : OP_LOWER;
            end
        endcase
        r = $urandom_range(19);
        case (w.operation)
            OP_INSERT: begin
                if (r < 10) begin
                    w.amount = near_minimum(2000);
                end else if (r < 12) begin
                    w.amount = cur_min > 50 ? cur_min - $urandom_range(1, 50) : '0;
                end else if (r < 15) begin
                    w.amount = $urandom;
                end else if (r < 17) begin
                    w.amount = AMOUNT_MAX;
                end else if (r < 18) begin
                    w.amount = '0;
                end else begin
                    w.amount = cur_min;
                end
            end
            OP_RAISE, OP_LOWER: begin
                if (r < 14) begin
                    w.amount = $urandom_range(300);
                end else if (r < 16) begin
                    w.amount = $urandom;
                end else if (r < 17) begin
                    w.amount = AMOUNT_MAX;
                end else begin
                    w.amount = '0;
                end
            end
            default: begin
                if (r < 16) begin
                    w.amount = $urandom_range(CAPACITY + 2);
                end else if (r < 18) begin
                    w.amount = $urandom;
                end else begin
                    w.amount = AMOUNT_MAX;
                end
            end
        endcase
        return w;
    endfunction

    initial begin
        t_mix     mix;
        t_in_word w;
        int       idle_pct;
        int       n;
        mix          = MIX_FILL;
        phase_min[0] = 31'd1000;
        phase_min[1] = AMOUNT_MAX;
        phase_min[2] = '0;
        phase_min[3] = $urandom;
        phase_min[4] = 31'd200;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty queries, extremes, duplicates, eviction at each minimum
        write_minimum('0);
        send_word(OP_QUERY, 31'd1, 9);
        send_word(OP_QUERY, '0, 9);
        send_word(OP_INSERT, '0, 9);
        send_word(OP_INSERT, AMOUNT_MAX, 9);
        send_word(OP_INSERT, 31'd5, 9);
        send_word(OP_INSERT, 31'd5, 9);
        send_word(OP_QUERY, 31'd1, 9);
        send_word(OP_QUERY, 31'd4, 9);
        send_word(OP_QUERY, 31'd5, 9);
        send_word(OP_QUERY, AMOUNT_MAX, 9);
        send_word(OP_RAISE, '0, 9);
        send_word(OP_RAISE, 31'd10, 9);
        send_word(OP_LOWER, '0, 9);
        send_word(OP_LOWER, 31'd12, 9);
        send_word(OP_QUERY, 31'd3, 9);
        write_minimum(31'd100);
        send_word(OP_INSERT, 31'd99, 9);
        send_word(OP_INSERT, 31'd100, 9);
        send_word(OP_LOWER, 31'd4, 9);
        send_word(OP_RAISE, AMOUNT_MAX, 9);
        send_word(OP_QUERY, 31'd1, 9);
        send_word(OP_QUERY, 31'd2, 9);
        write_minimum(AMOUNT_MAX);
        send_word(OP_INSERT, AMOUNT_MAX - 31'd1, 9);
        send_word(OP_INSERT, AMOUNT_MAX, 9);
        send_word(OP_LOWER, 31'd1, 9);

        // Random: each minimum setting opens with a burst that overfills the store
        for (n = 0; n < RANDOM_WORDS; n++) begin
            idle_pct = n < RANDOM_WORDS / 3 ? 9 : n < 2 * RANDOM_WORDS / 3 ? 69 : 0;
            if (n % PHASE_WORDS == 0) begin
                write_minimum(phase_min[n / PHASE_WORDS]);
            end
            if (n % PHASE_WORDS < BURST_WORDS) begin
                w.operation = OP_INSERT;
                w.amount    = near_minimum(3000);
            end else begin
                if (n % SEGMENT_WORDS == 0) begin
                    mix = t_mix'($urandom_range(2));
                end
                w = draw_word(mix);
            end
            send_word(w.operation, w.amount, idle_pct);
        end

        // Swing the offset far down, store entries far from it, then swing far up
        write_minimum('0);
        send_word(OP_INSERT, 31'd7, 0);
        send_word(OP_INSERT, 31'd9, 0);
        repeat (SWEEP_STEPS) send_word(OP_LOWER, AMOUNT_MAX, 0);
        send_word(OP_INSERT, '0, 0);
        send_word(OP_INSERT, AMOUNT_MAX, 0);
        send_word(OP_QUERY, 31'd1, 0);
        send_word(OP_QUERY, 31'd2, 0);
        repeat (2 * SWEEP_STEPS) send_word(OP_RAISE, AMOUNT_MAX, 0);
        send_word(OP_INSERT, 31'd5, 0);
        send_word(OP_QUERY, 31'd1, 0);
        send_word(OP_LOWER, '0, 0);
        send_word(OP_QUERY, 31'd3, 0);

        settle();
        repeat (CAPACITY + 8) @(posedge clk);

        $display("Ran %0d insert, %0d raise, %0d lower, %0d query words; %0d minimums.",
                 sent[OP_INSERT], sent[OP_RAISE], sent[OP_LOWER], sent[OP_QUERY], settings);
        $display("Queries found %0d entries, %0d inserts hit a full store; offset swung wide.",
                 found_count, drop_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
